>>> design/frc_pkg.sv
// Shared types, constants and a helper function of the flooding relay block.
package frc_pkg;

    localparam int CACHE_DEPTH = 32;
    localparam int TTL_CLASSES = 4;
    localparam int AW          = $clog2(CACHE_DEPTH);
    localparam int CW          = $clog2(CACHE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [7:0]  BCAST_ADDR     = 8'hFF;
    localparam logic [7:0]  DEF_TTL_RST    = 8'd10;
    localparam logic [31:0] CACHE_TIME_RST = 32'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ADDR    = 3'd0,
        CFG_DEFAULT_TTL  = 3'd1,
        CFG_CACHE_TIME   = 3'd2,
        CFG_DEDUP_EN     = 3'd3,
        CFG_CLASS_TYPES  = 3'd4,
        CFG_CLASS_VALUES = 3'd5,
        CFG_CLASS_VALID  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DR_NONE    = 3'd0,
        DR_ERROR   = 3'd1,
        DR_NO_DST  = 3'd2,
        DR_OWN_SRC = 3'd3,
        DR_TTL     = 3'd4,
        DR_DUP     = 3'd5
    } t_drop;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        from_upper;
        logic        rx_err;
        logic [7:0]  src_addr;
        logic [7:0]  dst_addr;
        logic [15:0] packet_id;
        logic [7:0]  ttl_in;
        logic [15:0] app_class;
        logic [31:0] packet_time;
        logic [31:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic        deliver_up;
        logic        forward_down;
        logic [2:0]  drop_reason;
        logic [7:0]  out_ttl;
        logic [31:0] relay_count;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  src;
        logic [15:0] id;
        logic [31:0] stamp;
    } t_entry;

    // TTL for a locally originated item; the lowest valid matching class wins.
    function automatic logic [7:0] class_ttl(
        input logic [63:0] types,
        input logic [31:0] values,
        input logic [3:0]  valid,
        input logic [15:0] traffic,
        input logic [7:0]  dflt
    );
        logic [7:0] ttl;
        ttl = dflt;
        for (int i = TTL_CLASSES - 1; i >= 0; i--) begin
            if (valid[i] && types[16*i +: 16] == traffic) begin
                ttl = values[8*i +: 8];
            end
        end
        return ttl;
    endfunction

endpackage

>>> design/frc_in_if.sv
// Valid/ready channel that carries one packet header item into the block.
interface frc_in_if import frc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/frc_out_if.sv
// Valid/ready channel that carries one relay decision item out of the block.
interface frc_out_if import frc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/flooding_relay_with_duplicate_cache_unit.sv
// Flooding relay decision unit: one header in, one deliver/relay/discard decision out.
// One item is worked on at a time. A packet from below that is eligible for relay while
// duplicate suppression is on scans the whole cache memory, one entry per cycle, through the
// single read port of the cache memory, and then passes the decide and finish states. Every
// other item goes from idle straight to the finish state. A finished decision sits in an
// output register, so the next item is taken while it waits. The cache valid bits are
// cleared by reset at once; no clearing pass is needed.
module flooding_relay_with_duplicate_cache_unit import frc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    frc_in_if.sink                i_in,
    frc_out_if.source             o_out
);

    // Configuration registers.
    logic [7:0]  r_node_addr;
    logic [7:0]  r_default_ttl;
    logic [31:0] r_max_time;
    logic        r_dedup_en;
    logic [63:0] r_class_types;
    logic [31:0] r_class_values;
    logic [3:0]  r_class_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr    <= '0;
            r_default_ttl  <= DEF_TTL_RST;
            r_max_time     <= CACHE_TIME_RST;
            r_dedup_en     <= 1'b1;
            r_class_types  <= '0;
            r_class_values <= '0;
            r_class_valid  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_ADDR:    r_node_addr    <= i_cfg_data[7:0];
                CFG_DEFAULT_TTL:  r_default_ttl  <= i_cfg_data[7:0];
                CFG_CACHE_TIME:   r_max_time     <= i_cfg_data[31:0];
                CFG_DEDUP_EN:     r_dedup_en     <= i_cfg_data[0];
                CFG_CLASS_TYPES:  r_class_types  <= i_cfg_data;
                CFG_CLASS_VALUES: r_class_values <= i_cfg_data[31:0];
                CFG_CLASS_VALID:  r_class_valid  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Control state.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt;
    logic            r_pend;
    logic [AW-1:0]   r_pidx;
    logic [AW-1:0]   r_ptr;
    logic [CACHE_DEPTH-1:0] r_valid;
    logic [31:0]     r_relay_cnt;
    logic            r_out_vld;

    // Item under work.
    t_out_item       r_res;
    t_out_item       r_out;
    logic [7:0]      r_src;
    logic [15:0]     r_id;
    logic [31:0]     r_ptime;
    logic [31:0]     r_now;
    logic [7:0]      r_ttl_m1;
    logic            r_hit;
    logic            r_known;
    logic [AW-1:0]   r_hit_idx;
    logic [31:0]     r_hit_time;

    // Cache memory.
    t_entry          mem [CACHE_DEPTH];
    t_entry          r_rd;

    logic            accept;
    logic            rd_en;
    logic            decide;
    logic            relay;
    logic            load_out;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;
    logic            ent_match;

    // Decision at accept for everything that does not need the cache.
    t_in_item        in_d;
    logic            a_up, a_down, a_scan, a_relay;
    t_drop           a_reason;
    logic [7:0]      a_ttl;

    assign in_d = i_in.data;

    always_comb begin
        a_up     = 1'b0;
        a_down   = 1'b0;
        a_scan   = 1'b0;
        a_relay  = 1'b0;
        a_reason = DR_NONE;
        a_ttl    = '0;
        if (in_d.rx_err) begin
            a_reason = DR_ERROR;
        end else if (in_d.dst_addr == 8'd0) begin
            a_reason = DR_NO_DST;
        end else if (in_d.from_upper) begin
            if (in_d.dst_addr == r_node_addr) begin
                a_up  = 1'b1;
                a_ttl = in_d.ttl_in;
            end else begin
                a_down = 1'b1;
                a_ttl  = class_ttl(r_class_types, r_class_values, r_class_valid,
                                   in_d.app_class, r_default_ttl);
            end
        end else if (in_d.dst_addr == r_node_addr) begin
            a_up  = 1'b1;
            a_ttl = (in_d.ttl_in == 8'd0) ? 8'd0 : in_d.ttl_in - 8'd1;
        end else if (in_d.src_addr == r_node_addr) begin
            a_reason = DR_OWN_SRC;
        end else begin
            if (in_d.dst_addr == BCAST_ADDR) begin
                a_up  = 1'b1;
                a_ttl = in_d.ttl_in;
            end
            if (in_d.ttl_in <= 8'd1) begin
                a_reason = DR_TTL;
            end else if (r_dedup_en) begin
                a_scan = 1'b1;
            end else begin
                a_down  = 1'b1;
                a_ttl   = in_d.ttl_in - 8'd1;
                a_relay = 1'b1;
            end
        end
    end

    // Next state and control.
    always_comb begin
        n_state  = r_state;
        accept   = 1'b0;
        rd_en    = 1'b0;
        decide   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                accept = i_in.valid;
                if (i_in.valid) begin
                    n_state = a_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                rd_en = (r_cnt < CW'(CACHE_DEPTH));
                // The last entry is compared in the cycle the counter reaches the depth.
                if (r_cnt == CW'(CACHE_DEPTH)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                decide  = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_vld || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    assign relay     = !r_hit || ((r_now - r_hit_time) > r_max_time);
    assign mem_we    = decide && relay;
    assign mem_waddr = r_hit ? r_hit_idx : r_ptr;
    assign mem_wdata = '{src: r_src, id: r_id,
                         stamp: (r_hit || !r_known) ? r_now : r_ptime};
    assign ent_match = r_pend && r_valid[r_pidx] && (r_rd.src == r_src);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= mem[r_cnt[AW-1:0]];
        end
    end

    // Control registers of the scan, the cache and the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_ptr       <= '0;
            r_valid     <= '0;
            r_relay_cnt <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if ((accept && a_relay) || (decide && relay)) begin
                r_relay_cnt <= r_relay_cnt + 32'd1;
            end
            if (decide && !r_hit) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr <= (r_ptr == AW'(CACHE_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload of the item under work.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res.deliver_up   <= a_up;
            r_res.forward_down <= a_down;
            r_res.drop_reason  <= a_reason;
            r_res.out_ttl      <= a_ttl;
            r_res.relay_count  <= '0;
            r_src              <= in_d.src_addr;
            r_id               <= in_d.packet_id;
            r_ptime            <= in_d.packet_time;
            r_now              <= in_d.now_time;
            r_ttl_m1           <= in_d.ttl_in - 8'd1;
            r_hit              <= 1'b0;
            r_known            <= 1'b0;
        end else begin
            if (ent_match) begin
                r_known <= 1'b1;
                if (!r_hit && r_rd.id == r_id) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_pidx;
                    r_hit_time <= r_rd.stamp;
                end
            end
            if (decide) begin
                if (relay) begin
                    r_res.forward_down <= 1'b1;
                    r_res.out_ttl      <= r_ttl_m1;
                end else begin
                    r_res.drop_reason  <= DR_DUP;
                end
            end
        end
        if (rd_en) begin
            r_pidx <= r_cnt[AW-1:0];
        end
        if (load_out) begin
            r_out <= '{deliver_up:   r_res.deliver_up,
                       forward_down: r_res.forward_down,
                       drop_reason:  r_res.drop_reason,
                       out_ttl:      r_res.out_ttl,
                       relay_count:  r_relay_cnt};
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // A relay never carries a drop reason.
    a_fwd_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.forward_down) |-> (o_out.data.drop_reason == DR_NONE))
        else $error("relayed item carries a drop reason");

    // The relay count moves only when an item is accepted or a cache decision is made.
    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept || decide) |=> $stable(r_relay_cnt))
        else $error("relay count changed outside a decision");

    // The replacement pointer stays inside the cache.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= AW'(CACHE_DEPTH - 1))
        else $error("replacement pointer out of range");

    // The cache is written only in the decision cycle that follows a full scan.
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ($past(r_state) == S_SCAN && $past(r_cnt) == CW'(CACHE_DEPTH)))
        else $error("cache written without a completed scan");

endmodule
